// ----- rtl/bbtt_pkg.sv -----
// Shared types and constants for the buffer tag table.
package bbtt_pkg;

	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_GET     = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_PIN     = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_UNDER  = 2'd2,
		ST_OVER   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_RDIDX,
		S_EXEC
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  dev;
		logic [31:0] block_number;
		logic [4:0]  buffer_index;
	} req_t;

	typedef struct packed {
		logic [4:0] entry_index;
		logic       hit;
		logic       needs_read;
		logic [7:0] count_after;
		status_t    status;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  dev;
		logic [31:0] blk;
		logic [7:0]  cnt;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic idx_rd;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic in_get;
		logic match_now;
		logic scan_last;
	} stat_t;

endpackage

// ----- rtl/bbtt_ctrl.sv -----
// Controller state machine: sequences scan, single-entry read and update.
module bbtt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bbtt_pkg::stat_t stat,
	output logic            busy,
	output bbtt_pkg::cmd_t  cmd
);

	bbtt_pkg::state_t state_q;
	bbtt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbtt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bbtt_pkg::S_IDLE: begin
				if (start) begin
					state_d = stat.in_get ? bbtt_pkg::S_SCAN : bbtt_pkg::S_RDIDX;
				end
			end
			bbtt_pkg::S_SCAN: begin
				// stop early on the first tag match
				if (stat.match_now) begin
					state_d = bbtt_pkg::S_EXEC;
				end else if (stat.scan_last) begin
					state_d = bbtt_pkg::S_TAIL;
				end
			end
			bbtt_pkg::S_TAIL:  state_d = bbtt_pkg::S_EXEC;
			bbtt_pkg::S_RDIDX: state_d = bbtt_pkg::S_EXEC;
			bbtt_pkg::S_EXEC:  state_d = bbtt_pkg::S_IDLE;
			default:           state_d = bbtt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q != bbtt_pkg::S_IDLE);
		cmd.load    = (state_q == bbtt_pkg::S_IDLE) && start;
		cmd.scan_rd = (state_q == bbtt_pkg::S_SCAN);
		cmd.idx_rd  = (state_q == bbtt_pkg::S_RDIDX);
		cmd.exec    = (state_q == bbtt_pkg::S_EXEC);
	end

endmodule

// ----- rtl/bbtt_datapath.sv -----
// Datapath: tag/count memory, scan compare, update logic and result register.
module bbtt_datapath #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bbtt_pkg::req_t  req,
	input  bbtt_pkg::cmd_t  cmd,
	output bbtt_pkg::stat_t stat,
	output bbtt_pkg::rsp_t  rsp,
	output logic            done
);

	localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_BUFFERS - 1);

	bbtt_pkg::entry_t mem [NUM_BUFFERS];

	bbtt_pkg::req_t   req_q;
	logic [AW-1:0]    addr_q;
	logic [NUM_BUFFERS-1:0] written_q;
	logic [NUM_BUFFERS-1:0] valid_q;

	bbtt_pkg::entry_t rd_s1;
	logic             written_s1;
	logic             scan_s1;
	logic [AW-1:0]    addr_s1;

	logic             hit_found_q;
	logic [AW-1:0]    hit_idx_q;
	logic [7:0]       hit_cnt_q;
	logic             free_found_q;
	logic [AW-1:0]    free_idx_q;

	logic             done_q;
	bbtt_pkg::rsp_t   rsp_q;

	logic [31:0]      idx_wide;
	logic [AW-1:0]    idx_addr;
	logic [31:0]      hit_wide;
	logic [31:0]      free_wide;
	logic             idx_ok;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	bbtt_pkg::entry_t ent;
	logic             match_now;
	logic             free_now;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	bbtt_pkg::entry_t wr_data;
	logic             set_valid;
	bbtt_pkg::rsp_t   res;

	assign idx_wide  = 32'(req_q.buffer_index);
	assign idx_addr  = idx_wide[AW-1:0];
	assign hit_wide  = 32'(hit_idx_q);
	assign free_wide = 32'(free_idx_q);
	assign idx_ok    = (idx_wide < NUM_BUFFERS);

	assign rd_en   = cmd.scan_rd || cmd.idx_rd;
	assign rd_addr = cmd.idx_rd ? idx_addr : addr_q;

	// entries never written since reset read as all zero
	assign ent       = written_s1 ? rd_s1 : '0;
	assign match_now = scan_s1 && (ent.dev == req_q.dev) && (ent.blk == req_q.block_number);
	assign free_now  = scan_s1 && (ent.cnt == 8'd0);

	assign stat.in_get    = (req.func == bbtt_pkg::FUNC_GET);
	assign stat.match_now = match_now;
	assign stat.scan_last = (addr_q == LAST);

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1      <= mem[rd_addr];
			written_s1 <= written_q[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			scan_s1      <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			written_q    <= '0;
			valid_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_rd;
			done_q  <= cmd.exec;
			if (cmd.load) begin
				addr_q       <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					addr_q <= addr_q + AW'(1);
				end
				if (match_now) begin
					hit_found_q <= 1'b1;
				end
				if (free_now) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.exec && wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (cmd.exec && set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// only the lowest-indexed match and free entry are kept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (match_now && !hit_found_q) begin
			hit_idx_q <= addr_s1;
			hit_cnt_q <= ent.cnt;
		end
		if (free_now && !free_found_q) begin
			free_idx_q <= addr_s1;
		end
		if (cmd.exec) begin
			rsp_q <= res;
		end
	end

	always_comb begin
		wr_en           = 1'b0;
		wr_addr         = idx_addr;
		wr_data         = ent;
		set_valid       = 1'b0;
		res.entry_index = req_q.buffer_index;
		res.hit         = 1'b0;
		res.needs_read  = 1'b0;
		res.count_after = 8'd0;
		res.status      = bbtt_pkg::ST_OK;
		case (req_q.func)
			bbtt_pkg::FUNC_GET: begin
				if (hit_found_q) begin
					res.entry_index = hit_wide[4:0];
					res.hit         = 1'b1;
					if (hit_cnt_q == bbtt_pkg::CNT_MAX) begin
						res.count_after = bbtt_pkg::CNT_MAX;
						res.status      = bbtt_pkg::ST_OVER;
					end else begin
						wr_en           = 1'b1;
						set_valid       = 1'b1;
						wr_addr         = hit_idx_q;
						wr_data.dev     = req_q.dev;
						wr_data.blk     = req_q.block_number;
						wr_data.cnt     = hit_cnt_q + 8'd1;
						res.needs_read  = !valid_q[hit_idx_q];
						res.count_after = hit_cnt_q + 8'd1;
					end
				end else if (free_found_q) begin
					wr_en           = 1'b1;
					set_valid       = 1'b1;
					wr_addr         = free_idx_q;
					wr_data.dev     = req_q.dev;
					wr_data.blk     = req_q.block_number;
					wr_data.cnt     = 8'd1;
					res.entry_index = free_wide[4:0];
					res.needs_read  = 1'b1;
					res.count_after = 8'd1;
				end else begin
					res.entry_index = 5'd0;
					res.status      = bbtt_pkg::ST_NOFREE;
				end
			end
			bbtt_pkg::FUNC_RELEASE: begin
				if (!idx_ok || ent.cnt == 8'd0) begin
					res.status = bbtt_pkg::ST_UNDER;
				end else begin
					wr_en           = 1'b1;
					wr_data.cnt     = ent.cnt - 8'd1;
					res.count_after = ent.cnt - 8'd1;
				end
			end
			bbtt_pkg::FUNC_PIN: begin
				if (!idx_ok) begin
					res.status = bbtt_pkg::ST_OVER;
				end else if (ent.cnt == bbtt_pkg::CNT_MAX) begin
					res.count_after = bbtt_pkg::CNT_MAX;
					res.status      = bbtt_pkg::ST_OVER;
				end else begin
					wr_en           = 1'b1;
					wr_data.cnt     = ent.cnt + 8'd1;
					res.count_after = ent.cnt + 8'd1;
				end
			end
			default: begin
				res.count_after = idx_ok ? ent.cnt : 8'd0;
			end
		endcase
	end

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

// ----- rtl/block_buffer_tag_table_core.sv -----
// Top level of the buffer tag table: controller plus datapath.
//
//  channel   handshake            payload        direction
//  request   start / busy         req (req_t)    in
//  result    done strobe          rsp (rsp_t)    out
//
// A get scans the table one entry per cycle from entry 0 and stops at the
// first tag match. Release, pin and the undefined op read one entry.
// One item at a time; busy stays high until the update. Reset clears the
// table at once through per-entry written and valid bits.
// The result is registered and shown for one cycle; the receiver cannot stall.
module block_buffer_tag_table_core #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bbtt_pkg::req_t req,
	output logic           done,
	output bbtt_pkg::rsp_t rsp
);

	bbtt_pkg::cmd_t  cmd;
	bbtt_pkg::stat_t stat;

	bbtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	bbtt_datapath #(
		.NUM_BUFFERS (NUM_BUFFERS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

// ----- rtl/bbtt_checker.sv -----
// Port-level checks for the buffer tag table, bound to the top level.
module bbtt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input bbtt_pkg::req_t req,
	input logic           done,
	input bbtt_pkg::rsp_t rsp
);

	// result beat closes the command: busy drops as the strobe shows
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result beat without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result beat for one command");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == bbtt_pkg::ST_NOFREE) |->
		(rsp.entry_index == 5'd0 && rsp.count_after == 8'd0 && !rsp.hit && !rsp.needs_read))
		else $error("full-table result carries nonzero fields");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.needs_read) |->
		(rsp.status == bbtt_pkg::ST_OK && (rsp.hit || rsp.count_after == 8'd1)))
		else $error("read request on a failed or inconsistent get");

endmodule

bind block_buffer_tag_table_core bbtt_checker u_bbtt_checker (.*);
